// ===== rtl/eeb_pkg.sv =====
// ----------------------------------------------------------------------------
// eeb_pkg: shared types for the extended Euclid block
// Transaction payloads and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package eeb_pkg;

    localparam int DATA_WIDTH_DEFAULT = 64;

    typedef struct packed {
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } eeb_in_t;

    typedef struct packed {
        logic        [63:0] gcd_value;
        logic signed [63:0] coef_a;
        logic signed [63:0] coef_b;
    } eeb_out_t;

    typedef struct packed {
        logic load;      // take operands, reset coefficients
        logic div_init;  // prime the divider with r / rr
        logic div_step;  // one quotient bit
        logic update;    // rotate remainder and coefficient pairs
        logic capture;   // write result register
    } eeb_cmd_t;

    typedef struct packed {
        logic rr_zero;
        logic div_last;
        logic out_free;
    } eeb_status_t;

endpackage

// ===== rtl/eeb_datapath.sv =====
// ----------------------------------------------------------------------------
// eeb_datapath: remainder and coefficient registers, bit-serial divider
// Restoring division, one quotient bit a cycle; q*uu and q*vv are built by
// shift-and-add alongside, so no multiplier is needed.
// ----------------------------------------------------------------------------
module eeb_datapath
    import eeb_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  eeb_cmd_t    cmd,
    input  eeb_in_t     in_data,
    output logic        rr_zero,
    output logic        div_last,
    output eeb_out_t    result
);
    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     r_reg, rr_reg, u_reg, v_reg, uu_reg, vv_reg;
    logic [W-1:0]     rem_reg, quo_reg, pu_reg, pv_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [W:0]       rem_t, rem_diff;
    logic             qbit;
    logic [W-1:0]     rem_next, pu_next, pv_next;
    logic signed [W-1:0] u_s, v_s;

    always_comb
    begin
        rem_t    = {rem_reg, quo_reg[W-1]};
        rem_diff = rem_t - {1'b0, rr_reg};
        qbit     = (rem_t >= {1'b0, rr_reg});
        rem_next = qbit ? rem_diff[W-1:0] : rem_t[W-1:0];
        pu_next  = {pu_reg[W-2:0], 1'b0} + (qbit ? uu_reg : '0);
        pv_next  = {pv_reg[W-2:0], 1'b0} + (qbit ? vv_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= CNT_W'(W - 1);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg  <= in_data.operand_a[W-1:0];
            rr_reg <= in_data.operand_b[W-1:0];
            u_reg  <= W'(1);
            v_reg  <= '0;
            uu_reg <= '0;
            vv_reg <= W'(1);
        end
        else if (cmd.update)
        begin
            r_reg  <= rr_reg;
            u_reg  <= uu_reg;
            v_reg  <= vv_reg;
            rr_reg <= rem_reg;
            uu_reg <= u_reg - pu_reg;
            vv_reg <= v_reg - pv_reg;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= r_reg;
            pu_reg  <= '0;
            pv_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], 1'b0};
            pu_reg  <= pu_next;
            pv_reg  <= pv_next;
        end
    end

    assign u_s      = u_reg;
    assign v_s      = v_reg;
    assign rr_zero  = (rr_reg == '0);
    assign div_last = (cnt_reg == '0);

    always_comb
    begin
        result.gcd_value = 64'(r_reg);
        result.coef_a    = 64'(u_s);
        result.coef_b    = 64'(v_s);
    end

endmodule

// ===== rtl/eeb_ctrl.sv =====
// ----------------------------------------------------------------------------
// eeb_ctrl: sequencer for the extended Euclid block
// Load, test remainder, run one division, rotate, repeat; then hand off.
// ----------------------------------------------------------------------------
module eeb_ctrl
    import eeb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  eeb_status_t status,
    output eeb_cmd_t    cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.rr_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_CHK;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/extended_euclid_bezout_64.sv =====
// ----------------------------------------------------------------------------
// extended_euclid_bezout_64: gcd with Bezout coefficients
// Extended Euclid over DATA_WIDTH-bit unsigned operands, iterative.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready/in_data carries operand_a and operand_b;
//    only the low DATA_WIDTH bits are used.
//  - Output channel out_valid/out_ready/out_data returns gcd_value and the
//    signed coefficients coef_a, coef_b with gcd = coef_a*a + coef_b*b
//    (mod 2^DATA_WIDTH), sign-extended to 64 bits.
//  - One result transaction per input transaction, in order.
//  - K is the number of remainder steps that a transaction takes
//    (0 when b is zero, at most about 93 for 64-bit operands). Each step
//    runs a restoring divider one quotient bit per cycle, which sets the
//    rate; one transaction is in work at a time.
//  - Input is taken again the cycle after the result is registered.
//  - The result sits in an output register, so a new transaction is taken
//    while the previous result still waits for out_ready.
//  - If the receiver stalls with the register full, the finished result
//    waits inside until the register frees; input is then held off.
//  - Reset (rst_n, asynchronous, low) empties the output register and
//    returns the sequencer to idle.
// ----------------------------------------------------------------------------
module extended_euclid_bezout_64
    import eeb_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  eeb_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output eeb_out_t out_data
);
    eeb_cmd_t    cmd;
    eeb_status_t status;
    eeb_out_t    result;
    eeb_out_t    out_data_reg;
    logic        out_valid_reg;
    logic        rr_zero, div_last;

    // result register is free when empty or being drained this cycle
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.rr_zero  = rr_zero;
    assign status.div_last = div_last;

    eeb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    eeb_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .rr_zero  (rr_zero),
        .div_last (div_last),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a capture never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // divider never runs against a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> !rr_zero)
        else $error("division by zero started");

    // one transaction in work: no new input straight after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

endmodule
